### rtl/survey_station_position_solver_unit_macros.svh
// Assertion macros for the survey station position solver
`ifndef SURVEY_STATION_POSITION_SOLVER_UNIT_MACROS_SVH
`define SURVEY_STATION_POSITION_SOLVER_UNIT_MACROS_SVH
// assert that an antecedent implies a consequent in the next cycle
`define SSPS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
// assert that a condition holds in the same cycle
`define SSPS_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
`endif

### rtl/ssps_pkg.sv
// Package: payload types, status codes, controller states and the saturating add of the solver
`timescale 1ns / 1ps
package ssps_pkg;
    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_GEN  = 2'd1,
        ACT_RDST = 2'd2,
        ACT_RDLG = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NODATA   = 3'd1,
        ST_FULL     = 3'd2,
        ST_DISJOINT = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         index;
        logic [15:0]        survey_id;
        logic [7:0]         from_station;
        logic [7:0]         to_station;
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [31:0] delta_z;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         station_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [5:0]         leg_start_index;
        logic [5:0]         leg_end_index;
        logic [6:0]         station_total;
        logic [6:0]         model_leg_total;
    } rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RDST,
        S_RDLG,
        S_FIRST_RD,
        S_FIRST_CHK,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_LOOK_RD,
        S_LOOK_CHK,
        S_DECIDE,
        S_POS_RD,
        S_POS_WR,
        S_LEG2,
        S_NEXT,
        S_DONE
    } state_t;

    localparam logic [7:0] SPLAY_RESET = 8'd255;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic neg);
        logic signed [33:0] s;
        begin
            s = neg ? ({{2{a[31]}}, a} - {{2{b[31]}}, b})
                    : ({{2{a[31]}}, a} + {{2{b[31]}}, b});
            if (s > 34'sd2147483647)
                sat_add = 32'sh7fffffff;
            else if (s < -34'sd2147483648)
                sat_add = 32'sh80000000;
            else
                sat_add = s[31:0];
        end
    endfunction
endpackage

### rtl/survey_station_position_solver_unit.sv
// Top level of the survey station position solver
`timescale 1ns / 1ps
// Usage:
// Commands enter on cmd when start is high and busy is low. Each command
// gives exactly one result on rsp, marked by done for one cycle; the
// receiver cannot stall, so results are never held.
// Load goes from idle straight to the done state; reads pass through their
// read state first (one synchronous memory read). Generate walks the slot
// memory in slot order, sweep after sweep; per slot a linear search of the
// station memory reads stored stations one by one for each end until a
// match, then a placement writes the new station and its leg. The search
// through the single station memory read port sets the time a model takes.
// Register splay_station_number at byte address 0 (APB, always ready).
// Reset clears slot valid bits, counts and the splay register (to 255);
// memory contents are undefined until written and are never read before.
// Station and model leg memories hold MODEL_ENTRIES entries each.
module survey_station_position_solver_unit #(
    parameter int LEG_SLOTS = 64,
    parameter int MODEL_ENTRIES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ssps_pkg::cmd_t    cmd,
    output logic              done,
    output ssps_pkg::rsp_t    rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ssps_pkg::*;

    localparam int SW = (LEG_SLOTS > 1) ? $clog2(LEG_SLOTS) : 1;
    localparam int MW = (MODEL_ENTRIES > 1) ? $clog2(MODEL_ENTRIES) : 1;
    localparam int SCW = $clog2(LEG_SLOTS + 1);
    localparam int MCW = $clog2(MODEL_ENTRIES + 1);

    state_t state_reg, state_next;

    logic [7:0]         splay_reg;
    logic [LEG_SLOTS-1:0] valid_reg, done_reg, done_next;
    logic [MCW-1:0]     st_used_reg, st_used_next;
    logic [MCW-1:0]     lg_used_reg, lg_used_next;
    cmd_t               cmd_reg;
    rsp_t               rsp_reg, rsp_next;
    logic               done_pulse_reg, done_pulse_next;
    logic [SCW-1:0]     slot_reg, slot_next;
    logic [MCW-1:0]     look_reg, look_next;
    logic               look_to_reg, look_to_next;
    logic               f_found_reg, f_found_next;
    logic               t_found_reg, t_found_next;
    logic [MW-1:0]      f_idx_reg, f_idx_next, t_idx_reg, t_idx_next;
    logic               changed_reg, changed_next;
    logic               complete_reg, complete_next;
    logic [111:0]       slot_dat_reg, slot_dat_next;
    logic [2:0]         err_reg, err_next;

    logic               s_we;
    logic [SW-1:0]      s_raddr;
    logic [127:0]       s_rdata;
    logic               st_we, lg_we;
    logic [MW-1:0]      st_waddr, st_raddr, lg_waddr, lg_raddr;
    logic [103:0]       st_wdata, st_rdata;
    logic [2*MW-1:0]    lg_wdata, lg_rdata;

    logic [7:0]         sl_from, sl_to;
    logic signed [31:0] sl_dx, sl_dy, sl_dz;
    logic [SW-1:0]      slot_idx;
    logic               slot_match;
    logic [7:0]         look_num;
    logic               neg;
    logic [MW-1:0]      known;
    logic [7:0]         new_num;

    assign slot_idx = slot_reg[SW-1:0];
    assign {sl_from, sl_to, sl_dx, sl_dy, sl_dz} = slot_dat_reg;
    assign slot_match = valid_reg[slot_idx] && (s_rdata[127:112] == cmd_reg.survey_id);
    assign look_num = look_to_reg ? sl_to : sl_from;
    assign neg = !f_found_reg;
    assign known = f_found_reg ? f_idx_reg : t_idx_reg;
    assign new_num = f_found_reg ? sl_to : sl_from;

    ssps_slot_mem #(.SLOTS(LEG_SLOTS), .AW(SW)) u_slot (
        .clk(clk), .we(s_we), .waddr(SW'(cmd.index)),
        .wdata({cmd.survey_id, cmd.from_station, cmd.to_station,
                cmd.delta_x, cmd.delta_y, cmd.delta_z}),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    ssps_model_mem #(.ENTRIES(MODEL_ENTRIES), .AW(MW)) u_model (
        .clk(clk),
        .st_we(st_we), .st_waddr(st_waddr), .st_wdata(st_wdata),
        .st_raddr(st_raddr), .st_rdata(st_rdata),
        .lg_we(lg_we), .lg_waddr(lg_waddr), .lg_wdata(lg_wdata),
        .lg_raddr(lg_raddr), .lg_rdata(lg_rdata)
    );

    assign pready = 1'b1;
    assign prdata = {24'd0, splay_reg};
    assign busy = (state_reg != S_IDLE);
    assign done = done_pulse_reg;
    assign rsp = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            splay_reg      <= SPLAY_RESET;
            valid_reg      <= '0;
            done_reg       <= '0;
            st_used_reg    <= '0;
            lg_used_reg    <= '0;
            done_pulse_reg <= 1'b0;
            slot_reg       <= '0;
            look_reg       <= '0;
            look_to_reg    <= 1'b0;
            f_found_reg    <= 1'b0;
            t_found_reg    <= 1'b0;
            changed_reg    <= 1'b0;
            complete_reg   <= 1'b0;
            err_reg        <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            st_used_reg    <= st_used_next;
            lg_used_reg    <= lg_used_next;
            done_pulse_reg <= done_pulse_next;
            slot_reg       <= slot_next;
            look_reg       <= look_next;
            look_to_reg    <= look_to_next;
            f_found_reg    <= f_found_next;
            t_found_reg    <= t_found_next;
            changed_reg    <= changed_next;
            complete_reg   <= complete_next;
            err_reg        <= err_next;
            if (psel && penable && pwrite && paddr == 2'd0)
            begin
                splay_reg <= pwdata[7:0];
            end
            if (s_we)
            begin
                valid_reg[SW'(cmd.index)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
        rsp_reg      <= rsp_next;
        f_idx_reg    <= f_idx_next;
        t_idx_reg    <= t_idx_next;
        slot_dat_reg <= slot_dat_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (action_t'(cmd.action))
                        ACT_LOAD: state_next = S_DONE;
                        ACT_GEN:  state_next = S_FIRST_RD;
                        ACT_RDST: state_next = S_RDST;
                        ACT_RDLG: state_next = S_RDLG;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_RDST:      state_next = S_DONE;
            S_RDLG:      state_next = S_DONE;
            S_FIRST_RD:  state_next = S_FIRST_CHK;
            S_FIRST_CHK:
            begin
                if (slot_match || slot_reg == SCW'(LEG_SLOTS - 1))
                    state_next = slot_match ? S_SLOT_RD : S_DONE;
                else
                    state_next = S_FIRST_RD;
            end
            S_SLOT_RD:   state_next = S_SLOT_CHK;
            S_SLOT_CHK:  state_next = (slot_match && !done_reg[slot_idx]) ? S_LOOK_RD : S_NEXT;
            S_LOOK_RD:   state_next = (look_reg >= st_used_reg) ?
                                      (look_to_reg ? S_DECIDE : S_LOOK_RD) : S_LOOK_CHK;
            S_LOOK_CHK:  state_next = S_LOOK_RD;
            S_DECIDE:    state_next = (f_found_reg || t_found_reg) ? S_POS_RD : S_NEXT;
            S_POS_RD:    state_next = S_POS_WR;
            S_POS_WR:
            begin
                if (st_used_reg >= MCW'(MODEL_ENTRIES) || lg_used_reg >= MCW'(MODEL_ENTRIES))
                    state_next = S_DONE;
                else if (f_found_reg && t_found_reg)
                    state_next = S_LEG2;
                else
                    state_next = S_NEXT;
            end
            S_LEG2:      state_next = (lg_used_reg >= MCW'(MODEL_ENTRIES)) ? S_DONE : S_NEXT;
            S_NEXT:
            begin
                if (slot_reg == SCW'(LEG_SLOTS - 1))
                    state_next = (complete_reg || !changed_reg) ? S_DONE : S_SLOT_RD;
                else
                    state_next = S_SLOT_RD;
            end
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        done_next       = done_reg;
        st_used_next    = st_used_reg;
        lg_used_next    = lg_used_reg;
        done_pulse_next = 1'b0;
        rsp_next        = rsp_reg;
        slot_next       = slot_reg;
        look_next       = look_reg;
        look_to_next    = look_to_reg;
        f_found_next    = f_found_reg;
        t_found_next    = t_found_reg;
        f_idx_next      = f_idx_reg;
        t_idx_next      = t_idx_reg;
        changed_next    = changed_reg;
        complete_next   = complete_reg;
        slot_dat_next   = slot_dat_reg;
        err_next        = err_reg;
        s_we            = 1'b0;
        s_raddr         = slot_idx;
        st_we           = 1'b0;
        st_waddr        = st_used_reg[MW-1:0];
        st_wdata        = '0;
        st_raddr        = look_reg[MW-1:0];
        lg_we           = 1'b0;
        lg_waddr        = lg_used_reg[MW-1:0];
        lg_wdata        = '0;
        lg_raddr        = MW'(cmd_reg.index);
        case (state_reg)
            S_IDLE:
            begin
                st_raddr = MW'(cmd.index);
                lg_raddr = MW'(cmd.index);
                err_next = ST_OK;
                if (start)
                begin
                    if (action_t'(cmd.action) == ACT_LOAD)
                    begin
                        if (int'(cmd.index) >= LEG_SLOTS)
                            err_next = ST_RANGE;
                        else
                            s_we = 1'b1;
                    end
                    if (action_t'(cmd.action) == ACT_GEN)
                    begin
                        st_used_next = '0;
                        lg_used_next = '0;
                        done_next    = '0;
                        slot_next    = '0;
                    end
                end
            end
            S_FIRST_RD:
            begin
                s_raddr = slot_idx;
            end
            S_FIRST_CHK:
            begin
                if (slot_match)
                begin
                    st_we        = 1'b1;
                    st_waddr     = '0;
                    st_wdata     = {s_rdata[111:104], 96'd0};
                    st_used_next = MCW'(1);
                    slot_next    = '0;
                    changed_next = 1'b0;
                    complete_next = 1'b1;
                end
                else if (slot_reg == SCW'(LEG_SLOTS - 1))
                    err_next = ST_NODATA;
                else
                    slot_next = slot_reg + SCW'(1);
            end
            S_SLOT_CHK:
            begin
                slot_dat_next = s_rdata[111:0];
                look_next     = '0;
                look_to_next  = 1'b0;
                f_found_next  = 1'b0;
                t_found_next  = 1'b0;
                st_raddr      = '0;
            end
            S_LOOK_RD:
            begin
                if (look_reg >= st_used_reg)
                begin
                    look_next    = '0;
                    look_to_next = 1'b1;
                end
            end
            S_LOOK_CHK:
            begin
                look_next = look_reg + MCW'(1);
                if (look_num != splay_reg && st_rdata[103:96] == look_num)
                begin
                    if (look_to_reg)
                    begin
                        t_found_next = 1'b1;
                        t_idx_next   = look_reg[MW-1:0];
                        look_next    = st_used_reg;
                    end
                    else
                    begin
                        f_found_next = 1'b1;
                        f_idx_next   = look_reg[MW-1:0];
                        look_next    = st_used_reg;
                    end
                end
            end
            S_DECIDE:
            begin
                st_raddr = known;
                if (!f_found_reg && !t_found_reg)
                    complete_next = 1'b0;
            end
            S_POS_RD:
            begin
                st_raddr = known;
            end
            S_POS_WR:
            begin
                if (st_used_reg >= MCW'(MODEL_ENTRIES))
                    err_next = ST_FULL;
                else
                begin
                    st_we = 1'b1;
                    st_wdata = {new_num,
                                sat_add(st_rdata[95:64], sl_dx, neg),
                                sat_add(st_rdata[63:32], sl_dy, neg),
                                sat_add(st_rdata[31:0], sl_dz, neg)};
                    st_used_next = st_used_reg + MCW'(1);
                    if (lg_used_reg >= MCW'(MODEL_ENTRIES))
                        err_next = ST_FULL;
                    else
                    begin
                        lg_we = 1'b1;
                        lg_wdata = {known, st_used_reg[MW-1:0]};
                        lg_used_next = lg_used_reg + MCW'(1);
                        done_next[slot_idx] = 1'b1;
                        changed_next = 1'b1;
                    end
                end
            end
            S_LEG2:
            begin
                if (lg_used_reg >= MCW'(MODEL_ENTRIES))
                    err_next = ST_FULL;
                else
                begin
                    lg_we = 1'b1;
                    lg_wdata = {t_idx_reg, MW'(st_used_reg - MCW'(1))};
                    lg_used_next = lg_used_reg + MCW'(1);
                end
            end
            S_NEXT:
            begin
                if (slot_reg == SCW'(LEG_SLOTS - 1))
                begin
                    slot_next = '0;
                    if (!complete_reg && !changed_reg)
                        err_next = ST_DISJOINT;
                    changed_next = 1'b0;
                    complete_next = 1'b1;
                end
                else
                    slot_next = slot_reg + SCW'(1);
            end
            S_DONE:
            begin
                done_pulse_next = 1'b1;
                rsp_next = '0;
                rsp_next.status = err_reg;
                rsp_next.station_total = 7'(st_used_reg);
                rsp_next.model_leg_total = 7'(lg_used_reg);
                if (action_t'(cmd_reg.action) == ACT_RDST)
                begin
                    if (int'(cmd_reg.index) >= int'(st_used_reg))
                        rsp_next.status = ST_RANGE;
                    else
                    begin
                        rsp_next.station_id = st_rdata[103:96];
                        rsp_next.pos_x = st_rdata[95:64];
                        rsp_next.pos_y = st_rdata[63:32];
                        rsp_next.pos_z = st_rdata[31:0];
                    end
                end
                if (action_t'(cmd_reg.action) == ACT_RDLG)
                begin
                    if (int'(cmd_reg.index) >= int'(lg_used_reg))
                        rsp_next.status = ST_RANGE;
                    else
                    begin
                        rsp_next.leg_start_index = 6'(lg_rdata[2*MW-1:MW]);
                        rsp_next.leg_end_index = 6'(lg_rdata[MW-1:0]);
                    end
                end
            end
            default:
            begin
                st_raddr = MW'(cmd_reg.index);
            end
        endcase
        if (state_reg == S_RDST || state_reg == S_RDLG)
        begin
            st_raddr = MW'(cmd_reg.index);
        end
    end
endmodule

### rtl/ssps_slot_mem.sv
// Leg slot memory: survey, station numbers and deltas, one read port
`timescale 1ns / 1ps
module ssps_slot_mem #(
    parameter int SLOTS = 64,
    parameter int AW = 6
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic [127:0]        wdata,
    input  logic [AW-1:0]       raddr,
    output logic [127:0]        rdata
);
    logic [127:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/ssps_model_mem.sv
// Model memory: station numbers and positions, and model leg ends
`timescale 1ns / 1ps
module ssps_model_mem #(
    parameter int ENTRIES = 64,
    parameter int AW = 6
) (
    input  logic                clk,
    input  logic                st_we,
    input  logic [AW-1:0]       st_waddr,
    input  logic [103:0]        st_wdata,
    input  logic [AW-1:0]       st_raddr,
    output logic [103:0]        st_rdata,
    input  logic                lg_we,
    input  logic [AW-1:0]       lg_waddr,
    input  logic [2*AW-1:0]     lg_wdata,
    input  logic [AW-1:0]       lg_raddr,
    output logic [2*AW-1:0]     lg_rdata
);
    logic [103:0]    st_mem [ENTRIES];
    logic [2*AW-1:0] lg_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        st_rdata <= st_mem[st_raddr];
        if (lg_we)
        begin
            lg_mem[lg_waddr] <= lg_wdata;
        end
        lg_rdata <= lg_mem[lg_raddr];
    end
endmodule

### rtl/ssps_checker.sv
// Port checker for the survey station position solver, bound to the top level
`timescale 1ns / 1ps
`include "survey_station_position_solver_unit_macros.svh"
module ssps_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input ssps_pkg::rsp_t rsp,
    input logic           pready
);
    import ssps_pkg::*;

    `SSPS_ASSERT_NOW(a_pready, clk, rst_n, 1'b1, pready, "pready low")
    `SSPS_ASSERT_NEXT(a_take, clk, rst_n, start && !busy, busy, "command not taken")
    `SSPS_ASSERT_NEXT(a_pulse, clk, rst_n, done, !done, "result strobe longer than a cycle")
    `SSPS_ASSERT_NOW(a_status, clk, rst_n, done, rsp.status <= ST_RANGE, "bad status code")
endmodule

bind survey_station_position_solver_unit ssps_checker u_ssps_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .rsp(rsp), .pready(pready)
);

### verif/tb_survey_station_position_solver_unit.sv
// Testbench for the survey station position solver: directed and random commands, self-checking
`timescale 1ns / 1ps
module tb_survey_station_position_solver_unit;
    import ssps_pkg::*;

    localparam int SLOTS   = 64;
    localparam int ENTRIES = 64;
    localparam int TARGET_CMDS = 1550;
    localparam int IDLE_LIMIT  = 4000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    cmd_t        cmd = '0;
    logic        done;
    rsp_t        rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    survey_station_position_solver_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // solver shadow state
    logic [7:0]         splay_num = SPLAY_RESET;
    bit                 leg_valid [SLOTS];
    logic [15:0]        leg_survey [SLOTS];
    logic [7:0]         leg_from [SLOTS];
    logic [7:0]         leg_to [SLOTS];
    logic signed [31:0] leg_delta [SLOTS][3];
    bit                 leg_placed [SLOTS];
    logic [7:0]         stn_num [ENTRIES];
    logic signed [31:0] stn_pos [ENTRIES][3];
    int                 link_a [ENTRIES];
    int                 link_b [ENTRIES];
    int                 stn_count = 0;
    int                 link_count = 0;

    cmd_t pending_cmds [$];
    rsp_t predicted_rsps [$];
    int   errors = 0;
    int   rsps_checked = 0;
    int   cmds_queued = 0;
    int   models_built [5];
    int   idle_cycles = 0;
    int   burst_left = 4;
    int   gap_left = 0;

    function automatic logic signed [31:0] clamp_sum(logic signed [31:0] a,
                                                     logic signed [31:0] b, bit neg);
        longint v;
        v = neg ? longint'(a) - longint'(b) : longint'(a) + longint'(b);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic int known_entry(logic [7:0] num);
        if (num == splay_num)
            return -1;
        for (int i = 0; i < stn_count; i++)
            if (stn_num[i] == num)
                return i;
        return -1;
    endfunction

    function automatic bit add_link(int a, int b);
        if (link_count >= ENTRIES)
            return 1'b0;
        link_a[link_count] = a;
        link_b[link_count] = b;
        link_count++;
        return 1'b1;
    endfunction

    function automatic bit push_stn(logic [7:0] num, logic signed [31:0] x,
                                    logic signed [31:0] y, logic signed [31:0] z);
        if (stn_count >= ENTRIES)
            return 1'b0;
        stn_num[stn_count] = num;
        stn_pos[stn_count][0] = x;
        stn_pos[stn_count][1] = y;
        stn_pos[stn_count][2] = z;
        stn_count++;
        return 1'b1;
    endfunction

    function automatic bit place_end(int s, int k, bit neg, logic [7:0] num);
        logic signed [31:0] p [3];
        for (int a = 0; a < 3; a++)
            p[a] = clamp_sum(stn_pos[k][a], leg_delta[s][a], neg);
        if (!push_stn(num, p[0], p[1], p[2]))
            return 1'b0;
        if (!add_link(k, stn_count - 1))
            return 1'b0;
        leg_placed[s] = 1'b1;
        return 1'b1;
    endfunction

    function automatic status_t build_model(logic [15:0] sid);
        bit found;
        bit changed;
        bit complete;
        int f;
        int t;
        found = 1'b0;
        stn_count = 0;
        link_count = 0;
        foreach (leg_placed[i])
            leg_placed[i] = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (leg_valid[i] && leg_survey[i] == sid)
            begin
                if (!push_stn(leg_from[i], 0, 0, 0))
                    return ST_FULL;
                found = 1'b1;
                break;
            end
        end
        if (!found)
            return ST_NODATA;
        forever
        begin
            changed = 1'b0;
            complete = 1'b1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!leg_valid[i] || leg_survey[i] != sid || leg_placed[i])
                    continue;
                f = known_entry(leg_from[i]);
                t = known_entry(leg_to[i]);
                if (f >= 0)
                begin
                    if (!place_end(i, f, 1'b0, leg_to[i]))
                        return ST_FULL;
                    if (t >= 0 && !add_link(t, stn_count - 1))
                        return ST_FULL;
                    changed = 1'b1;
                end
                else if (t >= 0)
                begin
                    if (!place_end(i, t, 1'b1, leg_from[i]))
                        return ST_FULL;
                    changed = 1'b1;
                end
                else
                    complete = 1'b0;
            end
            if (complete)
                return ST_OK;
            if (!changed)
                return ST_DISJOINT;
        end
    endfunction

    function automatic rsp_t compute_response(cmd_t c);
        rsp_t r;
        status_t st;
        r = '0;
        st = ST_OK;
        case (action_t'(c.action))
            ACT_LOAD:
            begin
                leg_valid[c.index] = 1'b1;
                leg_survey[c.index] = c.survey_id;
                leg_from[c.index] = c.from_station;
                leg_to[c.index] = c.to_station;
                leg_delta[c.index][0] = c.delta_x;
                leg_delta[c.index][1] = c.delta_y;
                leg_delta[c.index][2] = c.delta_z;
            end
            ACT_GEN:
            begin
                st = build_model(c.survey_id);
                models_built[st]++;
            end
            ACT_RDST:
            begin
                if (c.index >= stn_count)
                    st = ST_RANGE;
                else
                begin
                    r.station_id = stn_num[c.index];
                    r.pos_x = stn_pos[c.index][0];
                    r.pos_y = stn_pos[c.index][1];
                    r.pos_z = stn_pos[c.index][2];
                end
            end
            default:
            begin
                if (c.index >= link_count)
                    st = ST_RANGE;
                else
                begin
                    r.leg_start_index = link_a[c.index][5:0];
                    r.leg_end_index = link_b[c.index][5:0];
                end
            end
        endcase
        r.status = st;
        r.station_total = stn_count[6:0];
        r.model_leg_total = link_count[6:0];
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                predicted_rsps.push_back(compute_response(cmd));
                idle_cycles = 0;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd <= pending_cmds.pop_front();
                    start <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (done)
            begin
                idle_cycles = 0;
                if (predicted_rsps.size() == 0)
                begin
                    $display("%0t: result with none pending, actual %0h", $time, rsp);
                    errors++;
                end
                else
                begin
                    rsp_t w;
                    w = predicted_rsps.pop_front();
                    rsps_checked++;
                    compare_field("status", 32'(w.status), 32'(rsp.status));
                    compare_field("station_id", 32'(w.station_id), 32'(rsp.station_id));
                    compare_field("pos_x", w.pos_x, rsp.pos_x);
                    compare_field("pos_y", w.pos_y, rsp.pos_y);
                    compare_field("pos_z", w.pos_z, rsp.pos_z);
                    compare_field("leg_start_index", 32'(w.leg_start_index),
                                  32'(rsp.leg_start_index));
                    compare_field("leg_end_index", 32'(w.leg_end_index),
                                  32'(rsp.leg_end_index));
                    compare_field("station_total", 32'(w.station_total),
                                  32'(rsp.station_total));
                    compare_field("model_leg_total", 32'(w.model_leg_total),
                                  32'(rsp.model_leg_total));
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_survey_station_position_solver_unit failed");
                $finish;
            end
        end
    end

    task automatic queue_cmd(action_t act, int idx, logic [15:0] sid, logic [7:0] f,
                             logic [7:0] t, logic [31:0] dx, logic [31:0] dy,
                             logic [31:0] dz);
        cmd_t c;
        c.action = act;
        c.index = idx[5:0];
        c.survey_id = sid;
        c.from_station = f;
        c.to_station = t;
        c.delta_x = dx;
        c.delta_y = dy;
        c.delta_z = dz;
        pending_cmds.push_back(c);
        cmds_queued++;
    endtask

    function automatic logic [31:0] pick_delta();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return $urandom_range(0, 4000) - 2000;
        endcase
    endfunction

    task automatic drain();
        wait (pending_cmds.size() == 0 && !start && predicted_rsps.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_splay(logic [31:0] v);
        drain();
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= '0;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        splay_num = v[7:0];
    endtask

    task automatic queue_survey(logic [7:0] splay_v);
        logic [15:0] sid;
        logic [7:0]  known [$];
        logic [7:0]  a;
        logic [7:0]  b;
        int k;
        sid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
        k = $urandom_range(1, 6);
        known.push_back(8'($urandom_range(0, 12)));
        for (int i = 0; i < k; i++)
        begin
            a = known[$urandom_range(0, known.size() - 1)];
            case ($urandom_range(0, 7))
                0: b = known[$urandom_range(0, known.size() - 1)];
                1: b = splay_v;
                2: begin a = 8'($urandom_range(20, 30)); b = 8'($urandom_range(20, 30)); end
                default: b = 8'($urandom_range(0, 12));
            endcase
            known.push_back(b);
            if ($urandom_range(0, 1))
                queue_cmd(ACT_LOAD, $urandom_range(0, 63), sid, a, b,
                          pick_delta(), pick_delta(), pick_delta());
            else
                queue_cmd(ACT_LOAD, $urandom_range(0, 63), sid, b, a,
                          pick_delta(), pick_delta(), pick_delta());
        end
        queue_cmd(ACT_GEN, $urandom, sid, 8'($urandom), 8'($urandom), $urandom, $urandom,
                  $urandom);
        repeat ($urandom_range(3, 8))
            queue_cmd($urandom_range(0, 1) ? ACT_RDST : ACT_RDLG,
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, 10),
                      16'($urandom), 8'($urandom), 8'($urandom), $urandom, $urandom,
                      $urandom);
    endtask

    initial
    begin
        logic [7:0] splay_choices [5];
        int phase_end;
        foreach (models_built[i])
            models_built[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        queue_cmd(ACT_GEN, 0, 16'h0000, 0, 0, 0, 0, 0);
        queue_cmd(ACT_RDST, 0, 0, 0, 0, 0, 0, 0);
        queue_cmd(ACT_RDLG, 63, 0, 0, 0, 0, 0, 0);
        queue_cmd(ACT_LOAD, 0, 16'hffff, 8'd0, 8'd1, 32'h7fffffff, 32'h80000000, 32'd1);
        queue_cmd(ACT_LOAD, 1, 16'hffff, 8'd1, 8'd2, 32'h7fffffff, 32'h80000000, 32'hffffffff);
        queue_cmd(ACT_LOAD, 2, 16'hffff, 8'd2, 8'd0, 32'd5, 32'd6, 32'd7);
        queue_cmd(ACT_LOAD, 3, 16'hffff, 8'd3, 8'd2, 32'h80000000, 32'h7fffffff, 32'd9);
        queue_cmd(ACT_LOAD, 63, 16'hffff, 8'd2, 8'd255, 32'd1, 32'd2, 32'd3);
        queue_cmd(ACT_LOAD, 4, 16'hffff, 8'd255, 8'd0, 32'd10, 32'd20, 32'd30);
        queue_cmd(ACT_GEN, 0, 16'hffff, 0, 0, 0, 0, 0);
        for (int i = 0; i < 7; i++)
            queue_cmd(ACT_RDST, i, 0, 0, 0, 0, 0, 0);
        queue_cmd(ACT_RDLG, 0, 0, 0, 0, 0, 0, 0);
        queue_cmd(ACT_RDLG, 6, 0, 0, 0, 0, 0, 0);
        queue_cmd(ACT_RDLG, 63, 0, 0, 0, 0, 0, 0);
        queue_cmd(ACT_LOAD, 10, 16'h0000, 8'd7, 8'd8, 0, 0, 0);
        queue_cmd(ACT_LOAD, 11, 16'h0000, 8'd9, 8'd10, 0, 0, 0);
        queue_cmd(ACT_GEN, 0, 16'h0000, 0, 0, 0, 0, 0);
        queue_cmd(ACT_RDST, 1, 0, 0, 0, 0, 0, 0);

        // one long chain: with splay 0 it is disjoint, with splay 255 it overflows the station store
        write_splay(32'hffffff00);
        for (int i = 0; i < 64; i++)
            queue_cmd(ACT_LOAD, i, 16'h1234, 8'(i), 8'(i + 1), 32'd1000, 32'hfffffc18, 32'd3);
        queue_cmd(ACT_GEN, 0, 16'h1234, 0, 0, 0, 0, 0);
        queue_cmd(ACT_RDST, 63, 0, 0, 0, 0, 0, 0);
        queue_cmd(ACT_RDLG, 62, 0, 0, 0, 0, 0, 0);
        write_splay(32'h000000ff);
        queue_cmd(ACT_GEN, 0, 16'h1234, 0, 0, 0, 0, 0);
        queue_cmd(ACT_RDST, 2, 0, 0, 0, 0, 0, 0);

        splay_choices = '{8'd255, 8'd0, 8'd5, 8'd255, 8'd11};
        for (int p = 0; cmds_queued < TARGET_CMDS; p++)
        begin
            write_splay(($urandom & 32'hffffff00) | splay_choices[p % 5]);
            phase_end = cmds_queued + 300;
            while (cmds_queued < phase_end && cmds_queued < TARGET_CMDS)
            begin
                if ($urandom_range(0, 7) == 0)
                    queue_cmd(action_t'($urandom_range(0, 3)), $urandom, 16'($urandom),
                              8'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
                else
                    queue_survey(splay_num);
            end
        end
        drain();
        $display("%0d results checked over %0d commands", rsps_checked, cmds_queued);
        $display("models: %0d ok, %0d no data, %0d full, %0d disjoint", models_built[ST_OK],
                 models_built[ST_NODATA], models_built[ST_FULL], models_built[ST_DISJOINT]);
        if (errors == 0)
            $display("tb_survey_station_position_solver_unit passed");
        else
            $display("tb_survey_station_position_solver_unit failed");
        $finish;
    end
endmodule
